/* src/aob_pkg.sv */
// ----------------------------------------------------------------------------
// aob_pkg
// Shared types and constants for the ARGB over-blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aob_pkg;

	localparam int NUM_CH    = 3;
	localparam int CHAN_W    = 8;
	localparam int WSUM_W    = 16;
	localparam int NUM_W     = 24;
	localparam int DIV_STAGES = CHAN_W;

	localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;
	localparam logic [WSUM_W-1:0] ALPHA_ROUND = 16'd127;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [WSUM_W-1:0] wsum_t;
	typedef logic [NUM_W-1:0]  num_t;

	typedef struct packed {
		num_t  [NUM_CH-1:0] rem;
		chan_t [NUM_CH-1:0] quo;
		wsum_t              wsum;
		chan_t              alpha;
		logic               zero;
	} div_beat_t;

endpackage

`default_nettype wire

/* src/aob_in_if.sv */
// ----------------------------------------------------------------------------
// aob_in_if
// Input beat channel: source and destination ARGB8888 pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface aob_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_pixel;
	logic [31:0] dst_pixel;

	modport source (output valid, output src_pixel, output dst_pixel, input ready);
	modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

`default_nettype wire

/* src/aob_out_if.sv */
// ----------------------------------------------------------------------------
// aob_out_if
// Output beat channel: blended ARGB8888 pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface aob_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] blended_pixel;

	modport source (output valid, output blended_pixel, input ready);
	modport sink   (input valid, input blended_pixel, output ready);
endinterface

`default_nettype wire

/* src/aob_div_stage.sv */
// ----------------------------------------------------------------------------
// aob_div_stage
// One restoring-division stage: resolves quotient bit BIT on all channels.
// ----------------------------------------------------------------------------
`default_nettype none

module aob_div_stage #(
	parameter int BIT = 7
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vld_in,
	input  wire aob_pkg::div_beat_t beat_in,
	output logic                    vld,
	output aob_pkg::div_beat_t      beat
);
	import aob_pkg::*;

	div_beat_t nxt;
	num_t      trial;

	always_comb begin
		nxt   = beat_in;
		trial = num_t'(beat_in.wsum) << BIT;
		for (int c = 0; c < NUM_CH; c++) begin
			if (beat_in.rem[c] >= trial) begin
				nxt.rem[c]      = beat_in.rem[c] - trial;
				nxt.quo[c][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else if (en) begin
			vld <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat <= nxt;
		end
	end

endmodule

`default_nettype wire

/* src/argb_alpha_over_blend_unit.sv */
// ----------------------------------------------------------------------------
// argb_alpha_over_blend_unit
// Porter-Duff over of a straight-alpha ARGB8888 source onto a destination.
//
// pix_in carries one beat per pixel pair (src_pixel, dst_pixel); pix_out
// carries one blended_pixel beat for each input beat, in order.
// Throughput: one pixel per clock cycle when pix_out.ready stays high.
// Pipeline of 12 register stages: input capture, weight sum, channel
// products and alpha, numerators, then eight one-bit restoring division
// stages with one compare-subtract per stage.
// Both alphas zero gives an all-zero pixel.
// A stalled pix_out holds its beat; bubbles are squeezed out, and
// pix_in.ready drops only when every stage holds a waiting beat.
// Reset clears all stage valid bits; no beat is emitted until new input.
// ----------------------------------------------------------------------------
`default_nettype none

module argb_alpha_over_blend_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	aob_in_if.sink     pix_in,
	aob_out_if.source  pix_out
);
	import aob_pkg::*;

	localparam int NSTG = 4 + DIV_STAGES;

	logic [NSTG-1:0] vld;
	logic [NSTG-1:0] en;

	// stage 1: capture
	logic [31:0] src_s1, dst_s1;
	logic        vld_s1;

	// stage 2: weights
	wsum_t             ws_s2, wd_s2, sum_s2;
	chan_t [NUM_CH-1:0] cs_s2, cd_s2;
	logic              vld_s2;

	// stage 3: products and alpha
	num_t  [NUM_CH-1:0] ps_s3, pd_s3;
	wsum_t             sum_s3;
	chan_t             alpha_s3;
	logic              vld_s3;

	// stage 4: numerators
	div_beat_t         beat_s4;
	logic              vld_s4;

	div_beat_t         dbeat [DIV_STAGES+1];
	logic [DIV_STAGES:0] dvld;

	chan_t  as_w, ad_w, inv_as;
	wsum_t  ax;
	wsum_t  ar;

	always_comb begin
		vld[0] = vld_s1;
		vld[1] = vld_s2;
		vld[2] = vld_s3;
		vld[3] = vld_s4;
		for (int k = 0; k < DIV_STAGES; k++) begin
			vld[4+k] = dvld[k+1];
		end
		en[NSTG-1] = !vld[NSTG-1] || pix_out.ready;
		for (int k = NSTG-2; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign pix_in.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en[0]) vld_s1 <= pix_in.valid;
			if (en[1]) vld_s2 <= vld_s1;
			if (en[2]) vld_s3 <= vld_s2;
			if (en[3]) vld_s4 <= vld_s3;
		end
	end

	assign as_w   = src_s1[31:24];
	assign ad_w   = dst_s1[31:24];
	assign inv_as = CHAN_MAX - as_w;

	// x/255 for x < 65535: (x + (x >> 8) + 1) >> 8
	assign ax = sum_s2 + ALPHA_ROUND;
	assign ar = ax + {8'd0, ax[WSUM_W-1:8]} + 16'd1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			src_s1 <= pix_in.src_pixel;
			dst_s1 <= pix_in.dst_pixel;
		end
		if (en[1]) begin
			ws_s2  <= {as_w, 8'd0} - {8'd0, as_w};
			wd_s2  <= WSUM_W'(ad_w * inv_as);
			sum_s2 <= WSUM_W'({as_w, 8'd0} - {8'd0, as_w} + ad_w * inv_as);
			for (int c = 0; c < NUM_CH; c++) begin
				cs_s2[c] <= src_s1[c*CHAN_W +: CHAN_W];
				cd_s2[c] <= dst_s1[c*CHAN_W +: CHAN_W];
			end
		end
		if (en[2]) begin
			for (int c = 0; c < NUM_CH; c++) begin
				ps_s3[c] <= NUM_W'(cs_s2[c] * ws_s2);
				pd_s3[c] <= NUM_W'(cd_s2[c] * wd_s2);
			end
			sum_s3   <= sum_s2;
			alpha_s3 <= ar[15:8];
		end
		if (en[3]) begin
			for (int c = 0; c < NUM_CH; c++) begin
				beat_s4.rem[c] <= ps_s3[c] + pd_s3[c] + NUM_W'(sum_s3 >> 1);
				beat_s4.quo[c] <= '0;
			end
			beat_s4.wsum  <= sum_s3;
			beat_s4.alpha <= alpha_s3;
			beat_s4.zero  <= (sum_s3 == '0);
		end
	end

	assign dbeat[0] = beat_s4;
	assign dvld[0]  = vld_s4;

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		aob_div_stage #(
			.BIT (DIV_STAGES-1-j)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en[4+j]),
			.vld_in  (dvld[j]),
			.beat_in (dbeat[j]),
			.vld     (dvld[j+1]),
			.beat    (dbeat[j+1])
		);
	end

	div_beat_t last;
	assign last = dbeat[DIV_STAGES];

	assign pix_out.valid         = dvld[DIV_STAGES];
	assign pix_out.blended_pixel = last.zero ? 32'd0 :
		{last.alpha, last.quo[2], last.quo[1], last.quo[0]};

	a_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid |-> ((last.alpha == '0) == last.zero))
		else $error("alpha zero does not match zero weight sum");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && !last.zero |->
			(last.rem[0] < num_t'(last.wsum)) && (last.rem[1] < num_t'(last.wsum)) &&
			(last.rem[2] < num_t'(last.wsum)))
		else $error("division remainder not below divisor");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !en[3] |=> vld_s4 && $stable(beat_s4))
		else $error("stalled numerator stage changed");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (&vld) && !pix_out.ready)
		else $error("input stalled with a bubble in the pipeline");

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for argb_alpha_over_blend_unit. The bench predicts each
// over-blended pixel as its input beat is accepted and checks every output
// beat in order. Stimulus runs a directed set of corner pixels, then uniform
// random pairs, alpha-corner pairs and a back-to-back stream. Outside that
// stream the sender works in random bursts; the receiver stalls throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import aob_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	aob_in_if  pix_in ();
	aob_out_if pix_out ();

	argb_alpha_over_blend_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	always #5 clk = ~clk;

	logic [31:0] blend_q[$];
	logic [31:0] want_pixel;
	int unsigned n_sent = 0;
	int unsigned n_blended = 0;
	int unsigned n_fail = 0;
	int unsigned n_zero_pair = 0;
	int unsigned n_opaque_src = 0;
	int unsigned n_clear_src = 0;
	int unsigned burst_left = 0;
	bit          no_gaps = 1'b0;

	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_mode_left = 0;
	int unsigned rx_hold_left = 0;

	// straight-alpha over; zero weight sum gives an all-zero pixel
	function automatic logic [31:0] over_blend(input logic [31:0] src, input logic [31:0] dst);
		int unsigned a_src, a_dst, w_src, w_dst, w_sum, mix, c_src, c_dst;
		logic [31:0] pix;
		a_src = 32'(src[31:24]);
		a_dst = 32'(dst[31:24]);
		w_src = a_src * 32'(CHAN_MAX);
		w_dst = a_dst * (32'(CHAN_MAX) - a_src);
		w_sum = w_src + w_dst;
		pix = '0;
		if (w_sum == 0)
			return pix;
		mix = (w_sum + 32'(ALPHA_ROUND)) / 32'(CHAN_MAX);
		pix[31:24] = 8'(mix);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			c_src = 32'(src[ch*CHAN_W +: CHAN_W]);
			c_dst = 32'(dst[ch*CHAN_W +: CHAN_W]);
			mix = (c_src * w_src + c_dst * w_dst + w_sum / 2) / w_sum;
			pix[ch*CHAN_W +: CHAN_W] = 8'(mix);
		end
		return pix;
	endfunction

	// input beat capture and output beat check
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_in.valid === 1'b1 && pix_in.ready === 1'b1) begin
				blend_q = {blend_q, over_blend(pix_in.src_pixel, pix_in.dst_pixel)};
				if (pix_in.src_pixel[31:24] == 8'd0 && pix_in.dst_pixel[31:24] == 8'd0)
					n_zero_pair++;
				if (pix_in.src_pixel[31:24] == CHAN_MAX)
					n_opaque_src++;
				if (pix_in.src_pixel[31:24] == 8'd0)
					n_clear_src++;
			end
			if ($isunknown(pix_out.valid)) begin
				$error("pix_out.valid unknown after reset");
				n_fail++;
			end else if (pix_out.valid && pix_out.ready) begin
				if (blend_q.size() == 0) begin
					$error("blended_pixel beat with nothing expected: %h",
						pix_out.blended_pixel);
					n_fail++;
				end else begin
					want_pixel = blend_q.pop_front();
					n_blended++;
					if (pix_out.blended_pixel !== want_pixel) begin
						$error("blended_pixel mismatch: expected %h, actual %h",
							want_pixel, pix_out.blended_pixel);
						n_fail++;
					end
				end
			end
		end
	end

	// receiver back-pressure, switching among four random modes
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_mode_left <= $urandom_range(32, 160);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			RX_OPEN: pix_out.ready <= 1'b1;
			RX_COIN: pix_out.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: pix_out.ready <= ($urandom_range(0, 7) != 0);
			default: begin
				if (rx_hold_left != 0) begin
					rx_hold_left <= rx_hold_left - 1;
					pix_out.ready <= 1'b0;
				end else if ($urandom_range(0, 5) == 0) begin
					rx_hold_left <= $urandom_range(1, 12);
					pix_out.ready <= 1'b0;
				end else begin
					pix_out.ready <= 1'b1;
				end
			end
		endcase
	end

	task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 7);
			if (gap != 0) begin
				pix_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		pix_in.valid <= 1'b1;
		pix_in.src_pixel <= src;
		pix_in.dst_pixel <= dst;
		do @(posedge clk); while (pix_in.ready !== 1'b1);
		n_sent++;
	endtask

	task automatic wait_drained();
		pix_in.valid <= 1'b0;
		do @(posedge clk); while (n_blended < n_sent);
	endtask

	function automatic logic [7:0] corner_alpha();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			3: return CHAN_MAX;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] src_list[$];
		logic [31:0] dst_list[$];
		src_list = '{32'h00000000, 32'h00FFFFFF, 32'hFFFFFFFF, 32'hFF123456, 32'h00123456,
			32'h00FFFFFF, 32'h01FFFFFF, 32'h00000000, 32'h01000000, 32'hFE00FF00,
			32'h80FFFFFF, 32'h7F808080, 32'hAAAAAAAA, 32'h55555555, 32'h80000000,
			32'hFFFFFFFF, 32'h01FF00FF, 32'hFF000000};
		dst_list = '{32'h00000000, 32'h00ABCDEF, 32'hFFFFFFFF, 32'h80ABCDEF, 32'h80ABCDEF,
			32'hFF000000, 32'h00000000, 32'h01FFFFFF, 32'h01FFFFFF, 32'hFFFF00FF,
			32'h80000000, 32'h81808080, 32'h55555555, 32'hAAAAAAAA, 32'h00FFFFFF,
			32'h00000000, 32'hFF00FF00, 32'hFFFFFFFF};
		foreach (src_list[i])
			send_pixel(src_list[i], dst_list[i]);
		wait_drained();
	endtask

	task automatic test_random_uniform(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			send_pixel($urandom, $urandom);
			if (i == count / 2)
				wait_drained();
		end
		wait_drained();
	endtask

	task automatic test_alpha_corners(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_pixel({corner_alpha(), 24'($urandom)}, {corner_alpha(), 24'($urandom)});
		wait_drained();
	endtask

	task automatic test_back_to_back(input int unsigned count);
		no_gaps = 1'b1;
		for (int unsigned i = 0; i < count; i++)
			send_pixel($urandom, {corner_alpha(), 24'($urandom)});
		no_gaps = 1'b0;
		wait_drained();
	endtask

	initial begin
		pix_in.valid = 1'b0;
		pix_in.src_pixel = '0;
		pix_in.dst_pixel = '0;
		pix_out.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_uniform(320);
		test_alpha_corners(320);
		test_back_to_back(200);

		repeat (30) @(posedge clk);
		$display("Blended %0d of %0d pixels: %0d with both alphas zero, %0d opaque and %0d clear sources.",
			n_blended, n_sent, n_zero_pair, n_opaque_src, n_clear_src);
		$display("Sender ran in random bursts with drain pauses, receiver stalled in four patterns.");
		if (n_fail == 0 && blend_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			if (blend_q.size() != 0)
				$error("%0d blended_pixel beats never arrived", blend_q.size());
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

/* argb_alpha_over_blend_unit.f */
src/aob_pkg.sv
src/aob_in_if.sv
src/aob_out_if.sv
src/aob_div_stage.sv
src/argb_alpha_over_blend_unit.sv
verif/tb.sv
